// ----- design/isw_pkg.sv -----
// Shared types, constants and register codes for the inverse similarity warp address core.
package isw_pkg;

    // Field widths of the pixel words.
    localparam int unsigned COORD_W = 12;

    // Configuration register widths.
    localparam int unsigned COEF_W  = 24;
    localparam int unsigned TRANS_W = 29;
    localparam int unsigned ORIG_W  = 21;
    localparam int unsigned DIM_W   = 13;

    // Configuration port geometry.
    localparam int unsigned CFG_DATA_W  = 29;
    localparam int unsigned CFG_INDEX_W = 3;

    // Largest source dimension; larger programmed sizes are clamped to it.
    localparam int unsigned MAX_DIM = 4096;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    // Datapath widths.
    localparam int unsigned POS_W  = 22;   // centered integer coordinate
    localparam int unsigned OFS_W  = 31;   // Q.8 offset from translation
    localparam int unsigned PROD_W = 55;   // Q.24 product
    localparam int unsigned SUM_W  = 56;   // sum of two products
    localparam int unsigned FRAC_W = 24;   // fractional bits of the sum
    localparam int unsigned UV_W   = 32;   // integer part of the sum
    localparam int unsigned HALF_W = 34;   // source position in half units

    // Reset values of the configuration registers.
    localparam logic signed [COEF_W-1:0]  COEF_COS_RST = COEF_W'(65536);
    localparam logic signed [COEF_W-1:0]  COEF_SIN_RST = '0;
    localparam logic signed [TRANS_W-1:0] TRANS_RST    = '0;
    localparam logic signed [ORIG_W-1:0]  ORIG_RST     = '0;
    localparam logic [DIM_W-1:0]          WIDTH_RST    = DIM_W'(640);
    localparam logic [DIM_W-1:0]          HEIGHT_RST   = DIM_W'(480);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF_COS   = 3'd0,
        REG_COEF_SIN   = 3'd1,
        REG_TRANS_X    = 3'd2,
        REG_TRANS_Y    = 3'd3,
        REG_ORIGIN_X   = 3'd4,
        REG_TOP_Y      = 3'd5,
        REG_SRC_WIDTH  = 3'd6,
        REG_SRC_HEIGHT = 3'd7
    } cfg_reg_t;

    // Current transform settings as seen by the datapath.
    typedef struct packed {
        logic signed [COEF_W-1:0]  coef_cos;
        logic signed [COEF_W-1:0]  coef_sin;
        logic signed [TRANS_W-1:0] trans_x;
        logic signed [TRANS_W-1:0] trans_y;
        logic signed [ORIG_W-1:0]  origin_x;
        logic signed [ORIG_W-1:0]  top_y;
        logic [DIM_W-1:0]          width_eff;
        logic [DIM_W-1:0]          height_eff;
    } cfg_t;

endpackage

// ----- design/isw_if.sv -----
// Valid/ready channel interfaces for destination positions and source addresses.
interface isw_in_if;
    logic                            valid;
    logic                            ready;
    logic [isw_pkg::COORD_W-1:0]     dst_column;
    logic [isw_pkg::COORD_W-1:0]     dst_row;

    modport source (output valid, output dst_column, output dst_row, input ready);
    modport sink   (input valid, input dst_column, input dst_row, output ready);
endinterface

interface isw_out_if;
    logic                            valid;
    logic                            ready;
    logic                            inside_res;
    logic [isw_pkg::COORD_W-1:0]     src_column;
    logic [isw_pkg::COORD_W-1:0]     src_row;

    modport source (output valid, output inside_res, output src_column, output src_row,
                    input ready);
    modport sink   (input valid, input inside_res, input src_column, input src_row,
                    output ready);
endinterface

// ----- design/isw_cfg_regs.sv -----
// Configuration register file with source size clamping.
module isw_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [isw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [isw_pkg::CFG_DATA_W-1:0]     cfg_data,
    output isw_pkg::cfg_t                      cfg
);

    logic signed [isw_pkg::COEF_W-1:0]  coef_cos_reg;
    logic signed [isw_pkg::COEF_W-1:0]  coef_sin_reg;
    logic signed [isw_pkg::TRANS_W-1:0] trans_x_reg;
    logic signed [isw_pkg::TRANS_W-1:0] trans_y_reg;
    logic signed [isw_pkg::ORIG_W-1:0]  origin_x_reg;
    logic signed [isw_pkg::ORIG_W-1:0]  top_y_reg;
    logic [isw_pkg::DIM_W-1:0]          width_reg;
    logic [isw_pkg::DIM_W-1:0]          height_reg;

    // Register writes decoded by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_cos_reg <= isw_pkg::COEF_COS_RST;
            coef_sin_reg <= isw_pkg::COEF_SIN_RST;
            trans_x_reg  <= isw_pkg::TRANS_RST;
            trans_y_reg  <= isw_pkg::TRANS_RST;
            origin_x_reg <= isw_pkg::ORIG_RST;
            top_y_reg    <= isw_pkg::ORIG_RST;
            width_reg    <= isw_pkg::WIDTH_RST;
            height_reg   <= isw_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (isw_pkg::cfg_reg_t'(cfg_index))
                isw_pkg::REG_COEF_COS:   coef_cos_reg <= cfg_data[isw_pkg::COEF_W-1:0];
                isw_pkg::REG_COEF_SIN:   coef_sin_reg <= cfg_data[isw_pkg::COEF_W-1:0];
                isw_pkg::REG_TRANS_X:    trans_x_reg  <= cfg_data[isw_pkg::TRANS_W-1:0];
                isw_pkg::REG_TRANS_Y:    trans_y_reg  <= cfg_data[isw_pkg::TRANS_W-1:0];
                isw_pkg::REG_ORIGIN_X:   origin_x_reg <= cfg_data[isw_pkg::ORIG_W-1:0];
                isw_pkg::REG_TOP_Y:      top_y_reg    <= cfg_data[isw_pkg::ORIG_W-1:0];
                isw_pkg::REG_SRC_WIDTH:  width_reg    <= cfg_data[isw_pkg::DIM_W-1:0];
                isw_pkg::REG_SRC_HEIGHT: height_reg   <= cfg_data[isw_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Settings handed to the datapath; oversized source dimensions are clamped.
    always_comb
    begin
        cfg.coef_cos   = coef_cos_reg;
        cfg.coef_sin   = coef_sin_reg;
        cfg.trans_x    = trans_x_reg;
        cfg.trans_y    = trans_y_reg;
        cfg.origin_x   = origin_x_reg;
        cfg.top_y      = top_y_reg;
        cfg.width_eff  = (width_reg > isw_pkg::MAX_DIM_V) ? isw_pkg::MAX_DIM_V : width_reg;
        cfg.height_eff = (height_reg > isw_pkg::MAX_DIM_V) ? isw_pkg::MAX_DIM_V : height_reg;
    end

endmodule

// ----- design/isw_pipe.sv -----
// Five-register address pipeline: input, offsets, products, truncated sums, source address.
module isw_pipe
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  isw_pkg::cfg_t        cfg,
    isw_in_if.sink               in_ch,
    isw_out_if.source            out_ch
);

    localparam int unsigned CW = isw_pkg::COORD_W;

    // Stage valid bits.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic en0, en1, en2, en3, en4;

    // Stage payloads.
    logic [CW-1:0]                      col_reg, row_reg;
    logic signed [isw_pkg::OFS_W-1:0]   dx_reg, dy_reg;
    logic signed [isw_pkg::PROD_W-1:0]  pcx_reg, psy_reg, pcy_reg, psx_reg;
    logic signed [isw_pkg::UV_W-1:0]    u_reg, v_reg;
    logic                               inside_reg;
    logic [CW-1:0]                      scol_reg, srow_reg;

    // Combinational next values.
    logic signed [isw_pkg::POS_W-1:0]   x_next, y_next;
    logic signed [isw_pkg::OFS_W-1:0]   dx_next, dy_next;
    logic signed [isw_pkg::SUM_W-1:0]   su_next, sv_next, su_adj, sv_adj;
    logic signed [isw_pkg::SUM_W-1:0]   trunc_bias_u, trunc_bias_v;
    logic signed [isw_pkg::UV_W-1:0]    u_next, v_next;
    logic signed [isw_pkg::HALF_W-1:0]  tc_next, tr_next;
    logic signed [isw_pkg::HALF_W-2:0]  sc_next, sr_next;
    logic                               col_ok, row_ok, inside_next;

    // A stage advances when it is empty or the next one advances.
    assign en4 = !v4_reg || out_ch.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign in_ch.ready = en0;

    // Valid bits move with their words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= in_ch.valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Centered coordinates and their Q.8 offsets from the translation.
    always_comb
    begin
        x_next  = $signed({{(isw_pkg::POS_W-CW){1'b0}}, col_reg})
                + isw_pkg::POS_W'(cfg.origin_x);
        y_next  = isw_pkg::POS_W'(cfg.top_y)
                - $signed({{(isw_pkg::POS_W-CW){1'b0}}, row_reg});
        dx_next = isw_pkg::OFS_W'($signed({x_next, 8'b0})) - isw_pkg::OFS_W'(cfg.trans_x);
        dy_next = isw_pkg::OFS_W'($signed({y_next, 8'b0})) - isw_pkg::OFS_W'(cfg.trans_y);
    end

    // Sums of products, truncated toward zero to integers.
    always_comb
    begin
        su_next = isw_pkg::SUM_W'(pcx_reg) + isw_pkg::SUM_W'(psy_reg);
        sv_next = isw_pkg::SUM_W'(pcy_reg) - isw_pkg::SUM_W'(psx_reg);
        trunc_bias_u = su_next[isw_pkg::SUM_W-1]
                     ? $signed({{(isw_pkg::SUM_W-isw_pkg::FRAC_W){1'b0}},
                                {isw_pkg::FRAC_W{1'b1}}})
                     : '0;
        trunc_bias_v = sv_next[isw_pkg::SUM_W-1]
                     ? $signed({{(isw_pkg::SUM_W-isw_pkg::FRAC_W){1'b0}},
                                {isw_pkg::FRAC_W{1'b1}}})
                     : '0;
        su_adj = su_next + trunc_bias_u;
        sv_adj = sv_next + trunc_bias_v;
        u_next = su_adj[isw_pkg::SUM_W-1:isw_pkg::FRAC_W];
        v_next = sv_adj[isw_pkg::SUM_W-1:isw_pkg::FRAC_W];
    end

    // Add the half sizes in half units, truncate toward zero and check the bounds.
    // A position of minus one half truncates to zero and still counts as inside.
    always_comb
    begin
        tc_next = isw_pkg::HALF_W'($signed({u_reg, 1'b0}))
                + $signed({{(isw_pkg::HALF_W-isw_pkg::DIM_W){1'b0}}, cfg.width_eff});
        tr_next = $signed({{(isw_pkg::HALF_W-isw_pkg::DIM_W){1'b0}}, cfg.height_eff})
                - isw_pkg::HALF_W'($signed({v_reg, 1'b0}));
        sc_next = (tc_next == -isw_pkg::HALF_W'(1)) ? '0 : tc_next[isw_pkg::HALF_W-1:1];
        sr_next = (tr_next == -isw_pkg::HALF_W'(1)) ? '0 : tr_next[isw_pkg::HALF_W-1:1];
        col_ok  = !sc_next[isw_pkg::HALF_W-2]
               && (sc_next < $signed({{(isw_pkg::HALF_W-1-isw_pkg::DIM_W){1'b0}},
                                      cfg.width_eff}));
        row_ok  = !sr_next[isw_pkg::HALF_W-2]
               && (sr_next < $signed({{(isw_pkg::HALF_W-1-isw_pkg::DIM_W){1'b0}},
                                      cfg.height_eff}));
        inside_next = col_ok && row_ok;
    end

    // Payload registers load whenever their stage advances.
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            col_reg <= in_ch.dst_column;
            row_reg <= in_ch.dst_row;
        end
        if (en1)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en2)
        begin
            pcx_reg <= isw_pkg::PROD_W'(cfg.coef_cos) * isw_pkg::PROD_W'(dx_reg);
            psy_reg <= isw_pkg::PROD_W'(cfg.coef_sin) * isw_pkg::PROD_W'(dy_reg);
            pcy_reg <= isw_pkg::PROD_W'(cfg.coef_cos) * isw_pkg::PROD_W'(dy_reg);
            psx_reg <= isw_pkg::PROD_W'(cfg.coef_sin) * isw_pkg::PROD_W'(dx_reg);
        end
        if (en3)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
        if (en4)
        begin
            inside_reg <= inside_next;
            scol_reg   <= inside_next ? sc_next[CW-1:0] : '0;
            srow_reg   <= inside_next ? sr_next[CW-1:0] : '0;
        end
    end

    assign out_ch.valid      = v4_reg;
    assign out_ch.inside_res = inside_reg;
    assign out_ch.src_column = scol_reg;
    assign out_ch.src_row    = srow_reg;

endmodule

// ----- design/inverse_similarity_warp_address_core.sv -----
// Top level of the inverse similarity warp address core.
// Maps each destination pixel word (column, row) back through the programmed inverse
// similarity transform to the nearest source pixel and returns an inside flag with the
// source column and row (both zero when outside). One word is accepted every cycle
// unless backpressure has filled the pipeline; each word passes through the five
// pipeline registers: input, Q.8 offsets, the four 24x31 products, the truncated sums,
// and the result register. Backpressure stalls only as far as the pipeline is full, so
// bubbles are squeezed out. Registers are written through the plain write port and
// must only be changed while no word is in flight.
module inverse_similarity_warp_address_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [isw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [isw_pkg::CFG_DATA_W-1:0]     cfg_data,
    isw_in_if.sink                             in_ch,
    isw_out_if.source                          out_ch
);

    isw_pkg::cfg_t cfg;

    // Configuration registers.
    isw_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Address pipeline.
    isw_pipe u_pipe
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // An outside result carries a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.inside_res |-> out_ch.src_column == '0 && out_ch.src_row == '0)
        else $error("outside result with nonzero address");

    // An inside result lies within the clamped source size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.inside_res
        |-> {1'b0, out_ch.src_column} < cfg.width_eff
            && {1'b0, out_ch.src_row} < cfg.height_eff)
        else $error("inside result beyond source size");

    // A ready consumer never stalls the producer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready |-> in_ch.ready)
        else $error("input stalled while output is ready");

endmodule

// ----- bench/inverse_similarity_warp_address_core_tb.sv -----
// Self-checking testbench that sends destination pixel words and checks every address.
module inverse_similarity_warp_address_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RANDOM_PHASES    = 9;
    localparam int     WORDS_PER_PHASE  = 50;
    localparam int     DRAIN_CYCLES     = 10;
    localparam int     LONG_HOLD_AT     = 150;
    localparam int     LONG_HOLD_CYCLES = 120;
    localparam int     CYCLE_LIMIT      = 300000;
    localparam int     REPORT_LIMIT     = 10;
    localparam longint Q24_ONE          = 64'sd1 <<< isw_pkg::FRAC_W;

    // One source address word as the core returns it.
    typedef struct packed {
        logic                        in_src;
        logic [isw_pkg::COORD_W-1:0] col;
        logic [isw_pkg::COORD_W-1:0] row;
    } src_addr_t;

    // One row of the directed table: either a register write or a position word.
    typedef struct {
        bit                             is_reg;
        isw_pkg::cfg_reg_t              reg_sel;
        logic [isw_pkg::CFG_DATA_W-1:0] reg_val;
        logic [isw_pkg::COORD_W-1:0]    col;
        logic [isw_pkg::COORD_W-1:0]    row;
        bit                             known;
        src_addr_t                      want;
    } plan_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [isw_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [isw_pkg::CFG_DATA_W-1:0]  cfg_data;

    isw_in_if  pos_ch ();
    isw_out_if addr_ch ();

    inverse_similarity_warp_address_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (pos_ch),
        .out_ch    (addr_ch)
    );

    // Local copy of the transform settings, with the sizes already clamped.
    isw_pkg::cfg_t warp_cfg;
    src_addr_t     expected_addrs[$];
    plan_row_t     directed_plan[$];
    bit            pipe_dirty;
    int            words_sent;
    int            results_seen;
    int            inside_seen;
    int            mismatches;
    int            cfg_writes;
    bit            long_hold_done;
    int            tx_mode_left;
    bit            tx_steady;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Maps one destination position back to the expected source address.
    function automatic src_addr_t predict_address(input logic [isw_pkg::COORD_W-1:0] c,
                                                  input logic [isw_pkg::COORD_W-1:0] r);
        longint    x, y, dx, dy, u, v, w, h, sc, sr;
        src_addr_t res;
        w  = longint'(warp_cfg.width_eff);
        h  = longint'(warp_cfg.height_eff);
        x  = longint'(c) + longint'($signed(warp_cfg.origin_x));
        y  = longint'($signed(warp_cfg.top_y)) - longint'(r);
        dx = x * 256 - longint'($signed(warp_cfg.trans_x));
        dy = y * 256 - longint'($signed(warp_cfg.trans_y));
        // Q.24 sums; signed division truncates toward zero.
        u  = (longint'($signed(warp_cfg.coef_cos)) * dx
              + longint'($signed(warp_cfg.coef_sin)) * dy) / Q24_ONE;
        v  = (longint'($signed(warp_cfg.coef_cos)) * dy
              - longint'($signed(warp_cfg.coef_sin)) * dx) / Q24_ONE;
        // Half sizes are added in half units before the final truncation.
        sc = (2 * u + w) / 2;
        sr = (h - 2 * v) / 2;
        res = '0;
        if (sc >= 0 && sc < w && sr >= 0 && sr < h)
        begin
            res.in_src = 1'b1;
            res.col    = sc[isw_pkg::COORD_W-1:0];
            res.row    = sr[isw_pkg::COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic void load_reset_settings();
        warp_cfg.coef_cos   = isw_pkg::COEF_COS_RST;
        warp_cfg.coef_sin   = isw_pkg::COEF_SIN_RST;
        warp_cfg.trans_x    = isw_pkg::TRANS_RST;
        warp_cfg.trans_y    = isw_pkg::TRANS_RST;
        warp_cfg.origin_x   = isw_pkg::ORIG_RST;
        warp_cfg.top_y      = isw_pkg::ORIG_RST;
        warp_cfg.width_eff  = isw_pkg::WIDTH_RST;
        warp_cfg.height_eff = isw_pkg::HEIGHT_RST;
    endfunction

    function automatic logic [isw_pkg::DIM_W-1:0] clamp_size(
        input logic [isw_pkg::DIM_W-1:0] d);
        return (d > isw_pkg::MAX_DIM_V) ? isw_pkg::MAX_DIM_V : d;
    endfunction

    function automatic void note_failure(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0d ns: %s", $time, what);
    endfunction

    // Compares one returned word with the oldest expectation.
    function automatic void check_address();
        src_addr_t got;
        src_addr_t want;
        got = {addr_ch.inside_res, addr_ch.src_column, addr_ch.src_row};
        results_seen++;
        if (got.in_src === 1'b1)
            inside_seen++;
        if (expected_addrs.size() == 0)
        begin
            note_failure($sformatf("unexpected word: inside=%0b col=%0d row=%0d",
                                   got.in_src, got.col, got.row));
            return;
        end
        want = expected_addrs.pop_front();
        if (got.in_src !== want.in_src || got.col !== want.col || got.row !== want.row)
            note_failure($sformatf({"word %0d: expected inside=%0b col=%0d row=%0d, ",
                                    "got inside=%0b col=%0d row=%0d"},
                                   results_seen, want.in_src, want.col, want.row,
                                   got.in_src, got.col, got.row));
    endfunction

    // Gap before the next position word: mostly none, a few short, rarely long,
    // with whole stretches where the sender never pauses.
    function automatic int next_gap();
        int pick;
        if (tx_mode_left == 0)
        begin
            tx_steady    = ($urandom_range(0, 3) == 0);
            tx_mode_left = int'($urandom_range(10, 60));
        end
        tx_mode_left--;
        if (tx_steady)
            return 0;
        pick = int'($urandom_range(0, 99));
        if (pick < 60)
            return 0;
        if (pick < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    // A directed row with every field cleared.
    function automatic plan_row_t blank_row();
        plan_row_t p;
        p.is_reg  = 1'b0;
        p.reg_sel = isw_pkg::REG_COEF_COS;
        p.reg_val = '0;
        p.col     = '0;
        p.row     = '0;
        p.known   = 1'b0;
        p.want    = '0;
        return p;
    endfunction

    // Lowers valid and, if words are in flight, waits until every address has come back.
    task automatic wait_idle();
        pos_ch.valid <= 1'b0;
        if (pipe_dirty)
        begin
            @(posedge clk);
            while (expected_addrs.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            pipe_dirty = 1'b0;
        end
    endtask

    // Writes one register through the plain write port while the core is idle.
    task automatic write_reg(input isw_pkg::cfg_reg_t sel,
                             input logic [isw_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (sel)
            isw_pkg::REG_COEF_COS:   warp_cfg.coef_cos   = val[isw_pkg::COEF_W-1:0];
            isw_pkg::REG_COEF_SIN:   warp_cfg.coef_sin   = val[isw_pkg::COEF_W-1:0];
            isw_pkg::REG_TRANS_X:    warp_cfg.trans_x    = val[isw_pkg::TRANS_W-1:0];
            isw_pkg::REG_TRANS_Y:    warp_cfg.trans_y    = val[isw_pkg::TRANS_W-1:0];
            isw_pkg::REG_ORIGIN_X:   warp_cfg.origin_x   = val[isw_pkg::ORIG_W-1:0];
            isw_pkg::REG_TOP_Y:      warp_cfg.top_y      = val[isw_pkg::ORIG_W-1:0];
            isw_pkg::REG_SRC_WIDTH:  warp_cfg.width_eff  = clamp_size(val[isw_pkg::DIM_W-1:0]);
            isw_pkg::REG_SRC_HEIGHT: warp_cfg.height_eff = clamp_size(val[isw_pkg::DIM_W-1:0]);
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Offers one position word and records its expected address once it is taken.
    task automatic send_word(input logic [isw_pkg::COORD_W-1:0] c,
                             input logic [isw_pkg::COORD_W-1:0] r,
                             input bit known, input src_addr_t want);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            pos_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pos_ch.valid      <= 1'b1;
        pos_ch.dst_column <= c;
        pos_ch.dst_row    <= r;
        @(posedge clk);
        while (pos_ch.ready !== 1'b1)
            @(posedge clk);
        expected_addrs.push_back(known ? want : predict_address(c, r));
        pipe_dirty = 1'b1;
        words_sent++;
    endtask

    function automatic void plan_reg(input isw_pkg::cfg_reg_t sel, input int val);
        plan_row_t p;
        p = blank_row();
        p.is_reg  = 1'b1;
        p.reg_sel = sel;
        p.reg_val = isw_pkg::CFG_DATA_W'(val);
        directed_plan.push_back(p);
    endfunction

    function automatic void plan_word(input int c, input int r);
        plan_row_t p;
        p = blank_row();
        p.col = isw_pkg::COORD_W'(c);
        p.row = isw_pkg::COORD_W'(r);
        directed_plan.push_back(p);
    endfunction

    function automatic void plan_known(input int c, input int r, input bit in_src,
                                       input int sc, input int sr);
        plan_row_t p;
        p = blank_row();
        p.col         = isw_pkg::COORD_W'(c);
        p.row         = isw_pkg::COORD_W'(r);
        p.known       = 1'b1;
        p.want.in_src = in_src;
        p.want.col    = isw_pkg::COORD_W'(sc);
        p.want.row    = isw_pkg::COORD_W'(sr);
        directed_plan.push_back(p);
    endfunction

    // Directed table: reset settings, half-pixel edges, empty and oversized sources,
    // a quarter turn and both corners of the register ranges.
    function automatic void build_directed_plan();
        // Identity transform after reset: source = (col + 320, row + 240).
        plan_known(0, 0, 1'b1, 320, 240);
        plan_known(319, 239, 1'b1, 639, 479);
        plan_known(320, 0, 1'b0, 0, 0);
        plan_known(0, 240, 1'b0, 0, 0);
        plan_known(4095, 0, 1'b0, 0, 0);
        plan_known(4095, 4095, 1'b0, 0, 0);
        // Odd sizes so that a position of minus one half lands on column or row zero.
        plan_reg(isw_pkg::REG_SRC_WIDTH, 641);
        plan_reg(isw_pkg::REG_SRC_HEIGHT, 481);
        plan_reg(isw_pkg::REG_ORIGIN_X, -321);
        plan_reg(isw_pkg::REG_TOP_Y, 241);
        plan_known(0, 0, 1'b1, 0, 0);
        plan_known(641, 0, 1'b1, 640, 0);
        plan_known(642, 0, 1'b0, 0, 0);
        plan_known(0, 481, 1'b1, 0, 480);
        plan_known(0, 482, 1'b0, 0, 0);
        // A source of zero width holds no pixel at all.
        plan_reg(isw_pkg::REG_SRC_WIDTH, 0);
        plan_known(321, 240, 1'b0, 0, 0);
        plan_known(0, 0, 1'b0, 0, 0);
        // Oversized sources are clamped to the largest dimension.
        plan_reg(isw_pkg::REG_SRC_WIDTH, 8191);
        plan_reg(isw_pkg::REG_SRC_HEIGHT, 4097);
        plan_reg(isw_pkg::REG_ORIGIN_X, 0);
        plan_reg(isw_pkg::REG_TOP_Y, 0);
        plan_known(2047, 0, 1'b1, 4095, 2048);
        plan_known(2048, 2047, 1'b0, 0, 0);
        plan_known(0, 2047, 1'b1, 2048, 4095);
        // Quarter turn with fractional translation.
        plan_reg(isw_pkg::REG_COEF_COS, 0);
        plan_reg(isw_pkg::REG_COEF_SIN, 65536);
        plan_reg(isw_pkg::REG_TRANS_X, 100 * 256 + 128);
        plan_reg(isw_pkg::REG_TRANS_Y, -(50 * 256 + 64));
        plan_reg(isw_pkg::REG_SRC_WIDTH, 640);
        plan_reg(isw_pkg::REG_SRC_HEIGHT, 480);
        plan_word(100, 100);
        plan_word(4095, 0);
        plan_word(0, 4095);
        // Register extremes, one way and then the other.
        plan_reg(isw_pkg::REG_COEF_COS, 8388607);
        plan_reg(isw_pkg::REG_COEF_SIN, -8388608);
        plan_reg(isw_pkg::REG_TRANS_X, 268435455);
        plan_reg(isw_pkg::REG_TRANS_Y, -268435456);
        plan_reg(isw_pkg::REG_ORIGIN_X, -1048576);
        plan_reg(isw_pkg::REG_TOP_Y, 1048575);
        plan_word(0, 0);
        plan_word(4095, 4095);
        plan_reg(isw_pkg::REG_COEF_COS, -8388608);
        plan_reg(isw_pkg::REG_COEF_SIN, 8388607);
        plan_reg(isw_pkg::REG_TRANS_X, -268435456);
        plan_reg(isw_pkg::REG_TRANS_Y, 268435455);
        plan_reg(isw_pkg::REG_ORIGIN_X, 1048575);
        plan_reg(isw_pkg::REG_TOP_Y, -1048576);
        plan_word(0, 0);
        plan_word(4095, 4095);
        plan_word(2730, 1365);
    endfunction

    // Source size for a realistic phase: mostly modest, sometimes empty, at the largest size or oversized.
    function automatic int pick_size();
        int pick;
        pick = int'($urandom_range(0, 19));
        if (pick == 0)
            return 0;
        if (pick == 1)
            return int'(isw_pkg::MAX_DIM);
        if (pick == 2)
            return int'($urandom_range(isw_pkg::MAX_DIM + 1, 8191));
        return int'($urandom_range(16, 700));
    endfunction

    // Programs every register, either over its full range or as a plausible warp.
    task automatic program_settings(input bit wide);
        if (wide)
        begin
            write_reg(isw_pkg::REG_COEF_COS,   isw_pkg::CFG_DATA_W'($urandom()));
            write_reg(isw_pkg::REG_COEF_SIN,   isw_pkg::CFG_DATA_W'($urandom()));
            write_reg(isw_pkg::REG_TRANS_X,    isw_pkg::CFG_DATA_W'($urandom()));
            write_reg(isw_pkg::REG_TRANS_Y,    isw_pkg::CFG_DATA_W'($urandom()));
            write_reg(isw_pkg::REG_ORIGIN_X,   isw_pkg::CFG_DATA_W'($urandom()));
            write_reg(isw_pkg::REG_TOP_Y,      isw_pkg::CFG_DATA_W'($urandom()));
            write_reg(isw_pkg::REG_SRC_WIDTH,  isw_pkg::CFG_DATA_W'($urandom()));
            write_reg(isw_pkg::REG_SRC_HEIGHT, isw_pkg::CFG_DATA_W'($urandom()));
        end
        else
        begin
            write_reg(isw_pkg::REG_COEF_COS,
                      isw_pkg::CFG_DATA_W'(int'($urandom_range(0, 196608)) - 98304));
            write_reg(isw_pkg::REG_COEF_SIN,
                      isw_pkg::CFG_DATA_W'(int'($urandom_range(0, 196608)) - 98304));
            write_reg(isw_pkg::REG_TRANS_X,
                      isw_pkg::CFG_DATA_W'(int'($urandom_range(0, 153600)) - 76800));
            write_reg(isw_pkg::REG_TRANS_Y,
                      isw_pkg::CFG_DATA_W'(int'($urandom_range(0, 153600)) - 76800));
            write_reg(isw_pkg::REG_ORIGIN_X,
                      isw_pkg::CFG_DATA_W'(int'($urandom_range(0, 500)) - 400));
            write_reg(isw_pkg::REG_TOP_Y,      isw_pkg::CFG_DATA_W'($urandom_range(0, 500)));
            write_reg(isw_pkg::REG_SRC_WIDTH,  isw_pkg::CFG_DATA_W'(pick_size()));
            write_reg(isw_pkg::REG_SRC_HEIGHT, isw_pkg::CFG_DATA_W'(pick_size()));
        end
    endtask

    // Receiver: checks each accepted word, then decides ready for the next edge.
    // Once, mid-run, it holds off long enough for the core to fill and stall its input.
    initial
    begin : drain_addresses
        int hold;
        int mode_left;
        int pick;
        bit steady;
        hold      = 0;
        mode_left = 0;
        steady    = 1'b0;
        addr_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (addr_ch.valid === 1'b1 && addr_ch.ready === 1'b1)
                check_address();
            if (!long_hold_done && results_seen == LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold           = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = int'($urandom_range(20, 80));
            end
            mode_left--;
            if (hold > 0)
            begin
                hold--;
                addr_ch.ready <= 1'b0;
            end
            else if (steady)
                addr_ch.ready <= 1'b1;
            else
            begin
                pick = int'($urandom_range(0, 99));
                if (pick < 70)
                    addr_ch.ready <= 1'b1;
                else
                begin
                    addr_ch.ready <= 1'b0;
                    hold = (pick < 95) ? int'($urandom_range(0, 2))
                                       : int'($urandom_range(5, 25));
                end
            end
        end
    end

    // Run limit in cycles.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d words outstanding", cycles,
                 expected_addrs.size());
        $display("[inverse_similarity_warp_address_core] ERROR");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial
    begin : stimulus
        int  c;
        int  r;
        bit  wide;
        pos_ch.valid      <= 1'b0;
        pos_ch.dst_column <= '0;
        pos_ch.dst_row    <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        rst_n             <= 1'b0;
        pipe_dirty     = 1'b0;
        words_sent     = 0;
        results_seen   = 0;
        inside_seen    = 0;
        mismatches     = 0;
        cfg_writes     = 0;
        long_hold_done = 1'b0;
        tx_mode_left   = 0;
        tx_steady      = 1'b0;
        load_reset_settings();
        build_directed_plan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_reg)
                write_reg(directed_plan[i].reg_sel, directed_plan[i].reg_val);
            else
                send_word(directed_plan[i].col, directed_plan[i].row,
                          directed_plan[i].known, directed_plan[i].want);
        end

        // Random phases, each with fresh settings; the first covers full register ranges.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wide = (phase == 0) || ($urandom_range(0, 3) == 0);
            program_settings(wide);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if (wide || $urandom_range(0, 9) < 3)
                begin
                    c = int'($urandom_range(0, 4095));
                    r = int'($urandom_range(0, 4095));
                end
                else
                begin
                    c = int'($urandom_range(0, 700));
                    r = int'($urandom_range(0, 700));
                end
                send_word(isw_pkg::COORD_W'(c), isw_pkg::COORD_W'(r), 1'b0, '0);
            end
        end

        wait_idle();
        $display("Sent %0d position words under %0d register writes.",
                 words_sent, cfg_writes);
        $display("%0d of %0d addresses were inside; output held off for %0d cycles once.",
                 inside_seen, results_seen, LONG_HOLD_CYCLES);
        if (mismatches == 0)
            $display("[inverse_similarity_warp_address_core] OK");
        else
            $display("[inverse_similarity_warp_address_core] ERROR");
        $finish;
    end

endmodule
